[rtl/smfu_pkg.sv]
// ----------------------------------------------------------------------------
// smfu_pkg
// Shared codes and fixed widths for the stack machine frame unit.
// ----------------------------------------------------------------------------
package smfu_pkg;

   localparam int VALUE_PORT_WIDTH = 32;
   localparam int OFFSET_WIDTH     = 16;
   localparam int ADDR_PORT_WIDTH  = 16;
   localparam int BASE_WIDTH       = 16;
   localparam int COUNT_WIDTH      = 16;
   localparam int INDEX_WIDTH      = 18;
   localparam int WIDE_WIDTH       = 64;

   localparam logic [BASE_WIDTH-1:0]      BASE_MAX             = 16'hFFFF;
   localparam logic [ADDR_PORT_WIDTH-1:0] PROGRAM_LENGTH_RESET = 16'hFFFF;

   typedef enum logic [2:0] {
      ACT_PUSH      = 3'd0,
      ACT_POP       = 3'd1,
      ACT_PEEK      = 3'd2,
      ACT_LOCAL_GET = 3'd3,
      ACT_LOCAL_SET = 3'd4,
      ACT_CALL      = 3'd5,
      ACT_RETURN    = 3'd6,
      ACT_START     = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_OVERFLOW  = 3'd1,
      ST_UNDERFLOW = 3'd2,
      ST_BOUNDS    = 3'd3,
      ST_TARGET    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      RD_NONE    = 2'd0,
      RD_OPERAND = 2'd1,
      RD_LOCAL   = 2'd2
   } read_sel_type;

endpackage

[rtl/stack_machine_frame_unit_core.sv]
// ----------------------------------------------------------------------------
// stack_machine_frame_unit_core
// Result: registered at the input transfer, valid in the cycle after it.
// Throughput: 1 item per cycle while the result is not stalled; state
// registers update at the transfer edge and memory reads land in the result
// stage. Reset: synchronous; control state clears, stored operand and local
// values read as zero via per-entry valid bits, no clearing pass.
// ----------------------------------------------------------------------------
module stack_machine_frame_unit_core #(
   parameter int OPERAND_DEPTH  = 256,
   parameter int LOCAL_DEPTH    = 256,
   parameter int CALL_DEPTH_MAX = 64,
   parameter int VALUE_WIDTH    = 32,
   parameter int ADDRESS_WIDTH  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_action,
   input  logic signed [31:0]  req_value,
   input  logic signed [15:0]  req_offset,
   input  logic [15:0]         req_address,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic signed [31:0]  rsp_read_value,
   output logic [15:0]         rsp_pc,
   output logic                rsp_thread_active,
   input  logic                csr_write_enable,
   input  logic [15:0]         csr_write_data
);

   localparam int OAW      = $clog2(OPERAND_DEPTH);
   localparam int LAW      = $clog2(LOCAL_DEPTH);
   localparam int CAW      = $clog2(CALL_DEPTH_MAX);
   localparam int DW       = $clog2(OPERAND_DEPTH + 1);
   localparam int CDW      = $clog2(CALL_DEPTH_MAX + 1);
   localparam int PC_WIDTH = (ADDRESS_WIDTH < 16) ? ADDRESS_WIDTH : 16;
   localparam int IW       = smfu_pkg::INDEX_WIDTH;

   typedef struct packed {
      logic [PC_WIDTH-1:0]              pc;
      logic [smfu_pkg::BASE_WIDTH-1:0]  base;
      logic [DW-1:0]                    depth;
      logic [smfu_pkg::COUNT_WIDTH-1:0] count;
   } frame_rec_type;

   localparam int REC_WIDTH = $bits(frame_rec_type);

   // state
   logic [DW-1:0]                    op_depth_ff, op_depth_in;
   logic [smfu_pkg::BASE_WIDTH-1:0]  base_ff, base_in;
   logic [smfu_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic [CDW-1:0]                   call_depth_ff, call_depth_in;
   logic [PC_WIDTH-1:0]              pc_ff, pc_in;
   logic                             running_ff, running_in;
   logic [15:0]                      prog_len_ff;
   frame_rec_type                    top_ff, top_in;

   // result stage
   logic                   rsp_valid_ff;
   smfu_pkg::status_type   status_ff, status_in;
   smfu_pkg::read_sel_type rd_sel_ff, rd_sel_in;
   logic [PC_WIDTH-1:0]    out_pc_ff;
   logic                   out_active_ff;

   logic in_accept;

   // memory ports
   logic                   op_wr_en, op_rd_en;
   logic [OAW-1:0]         op_wr_addr, op_rd_addr;
   logic [VALUE_WIDTH-1:0] op_rd_data;
   logic                   loc_wr_en, loc_rd_en;
   logic [LAW-1:0]         loc_addr;
   logic [VALUE_WIDTH-1:0] loc_rd_data;
   logic                   fr_wr_en;
   logic [CAW-1:0]         fr_rd_addr;
   logic [REC_WIDTH-1:0]   fr_rd_data;
   frame_rec_type          new_rec;

   logic [smfu_pkg::WIDE_WIDTH-1:0] value_wide;
   logic [VALUE_WIDTH-1:0]          store_value;
   logic [smfu_pkg::WIDE_WIDTH-1:0] read_wide;
   logic signed [IW-1:0]            peek_idx, local_idx, off_ext, count_ext;
   logic [smfu_pkg::BASE_WIDTH:0]   base_sum;
   logic [CDW-1:0]                  call_depth_sel, fr_rd_ptr;
   logic [DW-1:0]                   op_dec;
   logic                            peek_ok, local_ok;

   assign in_accept = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;

   assign value_wide  = 64'(req_value);
   assign store_value = value_wide[VALUE_WIDTH-1:0];
   assign off_ext     = IW'(req_offset);
   assign count_ext   = IW'(count_ff);
   assign peek_idx    = IW'(op_depth_ff) - IW'(1) - off_ext;
   assign local_idx   = IW'(base_ff) + off_ext;
   assign peek_ok     = !peek_idx[IW-1] && (peek_idx < IW'(OPERAND_DEPTH));
   assign local_ok    = !local_idx[IW-1] && (local_idx < IW'(LOCAL_DEPTH));
   assign base_sum    = {1'b0, base_ff} + {1'b0, count_ff};
   assign op_dec      = op_depth_ff - DW'(1);

   assign new_rec.pc    = pc_ff;
   assign new_rec.base  = base_ff;
   assign new_rec.depth = op_depth_ff;
   assign new_rec.count = count_ff;

   always_comb begin
      op_depth_in   = op_depth_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      call_depth_in = call_depth_ff;
      pc_in         = pc_ff;
      running_in    = running_ff;
      top_in        = top_ff;
      status_in     = smfu_pkg::ST_OK;
      rd_sel_in     = smfu_pkg::RD_NONE;
      op_wr_en      = 1'b0;
      op_rd_en      = 1'b0;
      op_wr_addr    = op_depth_ff[OAW-1:0];
      op_rd_addr    = peek_idx[OAW-1:0];
      loc_wr_en     = 1'b0;
      loc_rd_en     = 1'b0;
      loc_addr      = local_idx[LAW-1:0];
      fr_wr_en      = 1'b0;
      case (smfu_pkg::action_type'(req_action))
         smfu_pkg::ACT_PUSH: begin
            if (op_depth_ff >= DW'(OPERAND_DEPTH)) begin
               status_in = smfu_pkg::ST_OVERFLOW;
            end else begin
               op_wr_en    = in_accept;
               op_depth_in = op_depth_ff + DW'(1);
            end
         end
         smfu_pkg::ACT_POP: begin
            if (op_depth_ff == '0) begin
               status_in = smfu_pkg::ST_UNDERFLOW;
            end else begin
               op_depth_in = op_dec;
               op_rd_addr  = op_dec[OAW-1:0];
               op_rd_en    = in_accept;
               rd_sel_in   = smfu_pkg::RD_OPERAND;
            end
         end
         smfu_pkg::ACT_PEEK: begin
            if (!peek_ok) begin
               status_in  = smfu_pkg::ST_BOUNDS;
               running_in = 1'b0;
            end else begin
               op_rd_en  = in_accept;
               rd_sel_in = smfu_pkg::RD_OPERAND;
            end
         end
         smfu_pkg::ACT_LOCAL_GET: begin
            if (!local_ok) begin
               status_in = smfu_pkg::ST_BOUNDS;
            end else begin
               loc_rd_en = in_accept;
               rd_sel_in = smfu_pkg::RD_LOCAL;
            end
         end
         smfu_pkg::ACT_LOCAL_SET: begin
            if (!local_ok) begin
               status_in = smfu_pkg::ST_BOUNDS;
            end else begin
               loc_wr_en = in_accept;
               if (off_ext >= count_ext) begin
                  count_in = smfu_pkg::COUNT_WIDTH'(off_ext + IW'(1));
               end
            end
         end
         smfu_pkg::ACT_CALL: begin
            if (call_depth_ff >= CDW'(CALL_DEPTH_MAX)) begin
               status_in  = smfu_pkg::ST_OVERFLOW;
               running_in = 1'b0;
            end else begin
               fr_wr_en      = in_accept;
               top_in        = new_rec;
               call_depth_in = call_depth_ff + CDW'(1);
               base_in       = base_sum[smfu_pkg::BASE_WIDTH] ? smfu_pkg::BASE_MAX
                                                              : base_sum[smfu_pkg::BASE_WIDTH-1:0];
               count_in      = '0;
               if (req_address >= prog_len_ff) begin
                  status_in  = smfu_pkg::ST_TARGET;
                  running_in = 1'b0;
               end else begin
                  pc_in = req_address[PC_WIDTH-1:0];
               end
            end
         end
         smfu_pkg::ACT_RETURN: begin
            if (call_depth_ff == '0) begin
               status_in  = smfu_pkg::ST_UNDERFLOW;
               running_in = 1'b0;
            end else begin
               call_depth_in = call_depth_ff - CDW'(1);
               pc_in         = top_ff.pc;
               base_in       = top_ff.base;
               op_depth_in   = top_ff.depth;
               count_in      = top_ff.count;
               top_in        = frame_rec_type'(fr_rd_data);
            end
         end
         smfu_pkg::ACT_START: begin
            op_depth_in   = '0;
            call_depth_in = '0;
            base_in       = '0;
            count_in      = '0;
            pc_in         = req_address[PC_WIDTH-1:0];
            running_in    = 1'b1;
         end
         default: begin
            status_in = smfu_pkg::ST_OK;
         end
      endcase
   end

   // record below the top, prefetched for the next return
   assign call_depth_sel = in_accept ? call_depth_in : call_depth_ff;
   assign fr_rd_ptr      = call_depth_sel - CDW'(2);
   assign fr_rd_addr     = fr_rd_ptr[CAW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         op_depth_ff   <= '0;
         base_ff       <= '0;
         count_ff      <= '0;
         call_depth_ff <= '0;
         pc_ff         <= '0;
         running_ff    <= 1'b0;
      end else if (in_accept) begin
         op_depth_ff   <= op_depth_in;
         base_ff       <= base_in;
         count_ff      <= count_in;
         call_depth_ff <= call_depth_in;
         pc_ff         <= pc_in;
         running_ff    <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         top_ff <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_len_ff <= smfu_pkg::PROGRAM_LENGTH_RESET;
      end else if (csr_write_enable) begin
         prog_len_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         status_ff     <= status_in;
         rd_sel_ff     <= rd_sel_in;
         out_pc_ff     <= pc_in;
         out_active_ff <= running_in;
      end
   end

   smfu_value_store #(
      .DEPTH (OPERAND_DEPTH),
      .WIDTH (VALUE_WIDTH)
   ) u_operand_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (op_wr_en),
      .wr_addr (op_wr_addr),
      .wr_data (store_value),
      .rd_en   (op_rd_en),
      .rd_addr (op_rd_addr),
      .rd_data (op_rd_data)
   );

   smfu_value_store #(
      .DEPTH (LOCAL_DEPTH),
      .WIDTH (VALUE_WIDTH)
   ) u_local_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (loc_wr_en),
      .wr_addr (loc_addr),
      .wr_data (store_value),
      .rd_en   (loc_rd_en),
      .rd_addr (loc_addr),
      .rd_data (loc_rd_data)
   );

   smfu_frame_store #(
      .DEPTH (CALL_DEPTH_MAX),
      .WIDTH (REC_WIDTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (fr_wr_en),
      .wr_addr (call_depth_ff[CAW-1:0]),
      .wr_data (REC_WIDTH'(new_rec)),
      .rd_addr (fr_rd_addr),
      .rd_data (fr_rd_data)
   );

   always_comb begin
      read_wide = '0;
      case (rd_sel_ff)
         smfu_pkg::RD_OPERAND: read_wide[VALUE_WIDTH-1:0] = op_rd_data;
         smfu_pkg::RD_LOCAL:   read_wide[VALUE_WIDTH-1:0] = loc_rd_data;
         default:              read_wide = '0;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_read_value    = read_wide[smfu_pkg::VALUE_PORT_WIDTH-1:0];
   assign rsp_pc            = smfu_pkg::ADDR_PORT_WIDTH'(out_pc_ff);
   assign rsp_thread_active = out_active_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      op_depth_ff <= DW'(OPERAND_DEPTH))
      else $error("operand depth beyond capacity");

   a_call_bound: assert property (@(posedge clock) disable iff (reset)
      call_depth_ff <= CDW'(CALL_DEPTH_MAX))
      else $error("call depth beyond capacity");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      in_accept |=> rsp_valid)
      else $error("transfer without result");

   a_no_accept_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !in_accept)
      else $error("transfer while result stalled");

   a_fail_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != smfu_pkg::ST_OK) |-> (rsp_read_value == '0))
      else $error("read value on failed action");

endmodule

[rtl/smfu_value_store.sv]
// ----------------------------------------------------------------------------
// smfu_value_store
// Value memory, one write and one registered read port. Per-entry valid bits
// make never-written entries read as zero right after reset.
// ----------------------------------------------------------------------------
module smfu_value_store #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] data_ff;
   logic             hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= mem[rd_addr];
         hit_ff  <= valid_ff[rd_addr];
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

[rtl/smfu_frame_store.sv]
// ----------------------------------------------------------------------------
// smfu_frame_store
// Call frame record memory. The read port samples every cycle so the record
// below the cached top is ready when a return arrives.
// ----------------------------------------------------------------------------
module smfu_frame_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 57
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= mem[rd_addr];
   end

   assign rd_data = data_ff;

endmodule

[tb/sv/stack_machine_frame_unit_core_checker.sv]
// ----------------------------------------------------------------------------
// stack_machine_frame_unit_core_checker
// Watches the request, result and register ports of the stack unit, keeps its
// own copy of the operand stack, local slots and frame records, predicts one
// result per request transfer and compares each result transfer against the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module stack_machine_frame_unit_core_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic signed [31:0] req_value,
   input  logic signed [15:0] req_offset,
   input  logic [15:0]        req_address,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [2:0]         rsp_status,
   input  logic signed [31:0] rsp_read_value,
   input  logic [15:0]        rsp_pc,
   input  logic               rsp_thread_active,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data,
   output int                 mismatch_count,
   output int                 results_owed
);

   localparam int OPERAND_SLOTS = 256;
   localparam int LOCAL_SLOTS   = 256;
   localparam int FRAME_SLOTS   = 64;

   typedef struct {
      smfu_pkg::status_type status;
      logic [31:0]          read_value;
      logic [15:0]          pc;
      logic                 active;
   } stack_result_type;

   typedef struct {
      logic [15:0] pc;
      int          base;
      int          depth;
      int          count;
   } frame_record_type;

   logic [31:0]      operand_mem [OPERAND_SLOTS];
   logic [31:0]      local_mem [LOCAL_SLOTS];
   frame_record_type frames [FRAME_SLOTS];
   int               operand_top;
   int               frame_base;
   int               local_count;
   int               call_level;
   logic [15:0]      current_pc;
   logic [15:0]      entry_pc;
   logic             running;
   logic [15:0]      program_length;
   stack_result_type expected_results [$];
   int               errors = 0;

   task automatic clear_model();
      for (int i = 0; i < OPERAND_SLOTS; i++) operand_mem[i] = '0;
      for (int i = 0; i < LOCAL_SLOTS; i++) local_mem[i] = '0;
      operand_top    = 0;
      frame_base     = 0;
      local_count    = 0;
      call_level     = 0;
      current_pc     = '0;
      entry_pc       = '0;
      running        = 1'b0;
      program_length = smfu_pkg::PROGRAM_LENGTH_RESET;
   endtask

   function automatic stack_result_type apply_stack_action(smfu_pkg::action_type act,
                                                           logic [31:0] value,
                                                           logic signed [15:0] offset,
                                                           logic [15:0] address);
      stack_result_type r;
      int slot;
      r.status     = smfu_pkg::ST_OK;
      r.read_value = '0;
      case (act)
         smfu_pkg::ACT_PUSH: begin
            if (operand_top >= OPERAND_SLOTS) begin
               r.status = smfu_pkg::ST_OVERFLOW;
            end else begin
               operand_mem[operand_top] = value;
               operand_top++;
            end
         end
         smfu_pkg::ACT_POP: begin
            if (operand_top == 0) begin
               r.status = smfu_pkg::ST_UNDERFLOW;
            end else begin
               operand_top--;
               r.read_value = operand_mem[operand_top];
            end
         end
         smfu_pkg::ACT_PEEK: begin
            slot = operand_top - 1 - int'(offset);
            if (slot < 0 || slot >= OPERAND_SLOTS) begin
               r.status = smfu_pkg::ST_BOUNDS;
               running  = 1'b0;
            end else begin
               r.read_value = operand_mem[slot];
            end
         end
         smfu_pkg::ACT_LOCAL_GET: begin
            slot = frame_base + int'(offset);
            if (slot < 0 || slot >= LOCAL_SLOTS) r.status = smfu_pkg::ST_BOUNDS;
            else r.read_value = local_mem[slot];
         end
         smfu_pkg::ACT_LOCAL_SET: begin
            slot = frame_base + int'(offset);
            if (slot < 0 || slot >= LOCAL_SLOTS) begin
               r.status = smfu_pkg::ST_BOUNDS;
            end else begin
               local_mem[slot] = value;
               if (int'(offset) >= local_count) local_count = int'(offset) + 1;
            end
         end
         smfu_pkg::ACT_CALL: begin
            if (call_level >= FRAME_SLOTS) begin
               r.status = smfu_pkg::ST_OVERFLOW;
               running  = 1'b0;
            end else begin
               frames[call_level] = '{pc: current_pc, base: frame_base,
                                      depth: operand_top, count: local_count};
               call_level++;
               frame_base = frame_base + local_count;
               if (frame_base > int'(smfu_pkg::BASE_MAX)) frame_base = int'(smfu_pkg::BASE_MAX);
               local_count = 0;
               if (address >= program_length) begin
                  r.status = smfu_pkg::ST_TARGET;
                  running  = 1'b0;
               end else begin
                  current_pc = address;
               end
            end
         end
         smfu_pkg::ACT_RETURN: begin
            if (call_level == 0) begin
               r.status = smfu_pkg::ST_UNDERFLOW;
               running  = 1'b0;
            end else begin
               call_level--;
               current_pc  = frames[call_level].pc;
               frame_base  = frames[call_level].base;
               operand_top = frames[call_level].depth;
               local_count = frames[call_level].count;
            end
         end
         smfu_pkg::ACT_START: begin
            operand_top = 0;
            call_level  = 0;
            frame_base  = 0;
            local_count = 0;
            current_pc  = address;
            entry_pc    = address;
            running     = 1'b1;
         end
         default: begin
            r.status = smfu_pkg::ST_OK;
         end
      endcase
      r.pc     = current_pc;
      r.active = running;
      return r;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   initial begin
      clear_model();
   end

   always @(posedge clock) begin
      stack_result_type want;
      if (reset) begin
         clear_model();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: result transfer with none expected, expected nothing, actual %0h",
                        $time, rsp_status);
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("read_value", want.read_value, rsp_read_value);
               check_field("pc", want.pc, rsp_pc);
               check_field("thread_active", want.active, rsp_thread_active);
            end
         end
         if (csr_write_enable) program_length = csr_write_data;
         if (req_valid && !req_stall) begin
            expected_results.push_back(apply_stack_action(
               smfu_pkg::action_type'(req_action), req_value, req_offset, req_address));
         end
      end
      mismatch_count <= errors;
      results_owed   <= expected_results.size();
   end

endmodule

[tb/sv/stack_machine_frame_unit_core_tb.sv]
// ----------------------------------------------------------------------------
// stack_machine_frame_unit_core_tb
// Drives the stack unit with directed corner actions, a full operand stack,
// a call chain past its limit and mixed random action streams under several
// program lengths, with random idle and stall cycles on both channels.
// ----------------------------------------------------------------------------
module stack_machine_frame_unit_core_tb;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int ITEM_TARGET    = 1100;
   localparam int SEGMENT_ITEMS  = 80;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   smfu_pkg::action_type req_action       = smfu_pkg::ACT_PUSH;
   logic signed [31:0]   req_value        = '0;
   logic signed [15:0]   req_offset       = '0;
   logic [15:0]          req_address      = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [2:0]           rsp_status;
   logic signed [31:0]   rsp_read_value;
   logic [15:0]          rsp_pc;
   logic                 rsp_thread_active;
   logic                 csr_write_enable = 1'b0;
   logic [15:0]          csr_write_data   = '0;

   int          mismatch_count;
   int          results_owed;
   int          items_sent   = 0;
   int          quiet_cycles = 0;
   bit          calm         = 1'b0;
   logic [15:0] length_now   = smfu_pkg::PROGRAM_LENGTH_RESET;

   stack_machine_frame_unit_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_value         (req_value),
      .req_offset        (req_offset),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_pc            (rsp_pc),
      .rsp_thread_active (rsp_thread_active),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   stack_machine_frame_unit_core_checker frame_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_value         (req_value),
      .req_offset        (req_offset),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_pc            (rsp_pc),
      .rsp_thread_active (rsp_thread_active),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .results_owed      (results_owed)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** stack_machine_frame_unit_core: FAILED **");
         $finish;
      end
   end

   // result side: random stall before each transfer
   initial begin : result_sink
      int hold;
      forever begin
         hold = calm ? 0 : $urandom_range(0, 9);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_action(smfu_pkg::action_type act, logic [31:0] value,
                              logic [15:0] offset, logic [15:0] address);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_value   <= value;
      req_offset  <= offset;
      req_address <= address;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_program_length(logic [15:0] length);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= length;
      length_now        = length;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [15:0] slot_offset();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return 16'($urandom_range(0, 12));
      if (pick < 8) return 16'(0 - $urandom_range(1, 8));
      if (pick < 9) return 16'($urandom_range(250, 260));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] call_target();
      if ($urandom_range(0, 3) == 0 || length_now == 0) return 16'($urandom);
      return 16'($urandom_range(0, 32'(length_now) - 1));
   endfunction

   function automatic logic [15:0] rand16();
      return 16'($urandom);
   endfunction

   task automatic send_mixed();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 26) send_action(smfu_pkg::ACT_PUSH, $urandom, rand16(), rand16());
      else if (pick < 42) send_action(smfu_pkg::ACT_POP, $urandom, rand16(), rand16());
      else if (pick < 54) send_action(smfu_pkg::ACT_PEEK, $urandom, slot_offset(), rand16());
      else if (pick < 66)
         send_action(smfu_pkg::ACT_LOCAL_GET, $urandom, slot_offset(), rand16());
      else if (pick < 80)
         send_action(smfu_pkg::ACT_LOCAL_SET, $urandom, slot_offset(), rand16());
      else if (pick < 89) send_action(smfu_pkg::ACT_CALL, $urandom, rand16(), call_target());
      else if (pick < 98) send_action(smfu_pkg::ACT_RETURN, $urandom, rand16(), rand16());
      else send_action(smfu_pkg::ACT_START, $urandom, rand16(), rand16());
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // corner actions, thread inactive out of reset
      send_action(smfu_pkg::ACT_POP, '0, '0, '0);
      send_action(smfu_pkg::ACT_RETURN, '0, '0, '0);
      send_action(smfu_pkg::ACT_PEEK, '0, 16'h0000, '0);
      send_action(smfu_pkg::ACT_START, '0, '0, 16'hFFFF);
      send_action(smfu_pkg::ACT_PUSH, 32'h8000_0000, '0, '0);
      send_action(smfu_pkg::ACT_PUSH, 32'h7FFF_FFFF, '0, '0);
      send_action(smfu_pkg::ACT_PEEK, '0, 16'h0000, '0);
      send_action(smfu_pkg::ACT_PEEK, '0, 16'hFFFF, '0);
      send_action(smfu_pkg::ACT_PEEK, '0, 16'h8000, '0);
      send_action(smfu_pkg::ACT_PEEK, '0, 16'h7FFF, '0);
      send_action(smfu_pkg::ACT_POP, '0, '0, '0);
      send_action(smfu_pkg::ACT_POP, '0, '0, '0);
      send_action(smfu_pkg::ACT_POP, '0, '0, '0);
      send_action(smfu_pkg::ACT_START, '0, '0, 16'h0000);
      send_action(smfu_pkg::ACT_LOCAL_SET, 32'hFFFF_FFFF, 16'd255, '0);
      send_action(smfu_pkg::ACT_LOCAL_SET, 32'h1234_5678, 16'd256, '0);
      send_action(smfu_pkg::ACT_LOCAL_GET, '0, 16'd255, '0);
      send_action(smfu_pkg::ACT_LOCAL_GET, '0, 16'hFFFF, '0);
      send_action(smfu_pkg::ACT_LOCAL_SET, 32'h0000_0000, 16'd2, '0);
      send_action(smfu_pkg::ACT_CALL, '0, '0, 16'h1234);
      send_action(smfu_pkg::ACT_LOCAL_GET, '0, 16'hFFFF, '0);
      send_action(smfu_pkg::ACT_CALL, '0, '0, 16'hFFFF);
      send_action(smfu_pkg::ACT_RETURN, '0, '0, '0);
      send_action(smfu_pkg::ACT_RETURN, '0, '0, '0);

      // operand stack to full and back past empty
      send_action(smfu_pkg::ACT_START, $urandom, rand16(), rand16());
      repeat (257) send_action(smfu_pkg::ACT_PUSH, $urandom, rand16(), rand16());
      send_action(smfu_pkg::ACT_PEEK, $urandom, 16'd0, rand16());
      send_action(smfu_pkg::ACT_PEEK, $urandom, 16'd255, rand16());
      send_action(smfu_pkg::ACT_PEEK, $urandom, 16'd256, rand16());
      send_action(smfu_pkg::ACT_PEEK, $urandom, 16'hFFFF, rand16());
      repeat (6)
         send_action(smfu_pkg::ACT_PEEK, $urandom, 16'($urandom_range(0, 260)), rand16());
      repeat (257) send_action(smfu_pkg::ACT_POP, $urandom, rand16(), rand16());

      // call chain past the frame limit and unwound past empty
      send_action(smfu_pkg::ACT_START, $urandom, rand16(), rand16());
      repeat (66) begin
         if ($urandom_range(0, 1) == 1)
            send_action(smfu_pkg::ACT_LOCAL_SET, $urandom, 16'($urandom_range(0, 3)),
                        rand16());
         send_action(smfu_pkg::ACT_CALL, $urandom, rand16(), call_target());
      end
      repeat (66) begin
         send_action(smfu_pkg::ACT_RETURN, $urandom, rand16(), rand16());
         if ($urandom_range(0, 3) == 0)
            send_action(smfu_pkg::ACT_LOCAL_GET, $urandom, slot_offset(), rand16());
      end

      for (int seg = 0; items_sent < ITEM_TARGET; seg++) begin
         case (seg % 5)
            0: write_program_length(16'h0000);
            1: write_program_length(16'h0001);
            2: write_program_length(16'hFFFF);
            3: write_program_length(16'h0400);
            default: write_program_length(16'($urandom));
         endcase
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 1)
            send_action(smfu_pkg::ACT_START, $urandom, rand16(), rand16());
         repeat (SEGMENT_ITEMS) send_mixed();
      end

      calm = 1'b0;
      settle();
      if (mismatch_count == 0) begin
         $display("** stack_machine_frame_unit_core: PASSED **");
      end else begin
         $display("** stack_machine_frame_unit_core: FAILED **");
      end
      $finish;
   end

endmodule
